[design/summed_area_box_sum_macros.svh]
// assertion helpers shared by the block
`ifndef SUMMED_AREA_BOX_SUM_MACROS_SVH
`define SUMMED_AREA_BOX_SUM_MACROS_SVH

// same-cycle implication
`define SAB_ASSERT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("sab assertion failed");

// next-cycle implication
`define SAB_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("sab assertion failed");

`endif

[design/sab_pkg.sv]
package sab_pkg;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	localparam int COORD_W     = 7;
	localparam int COUNT_W     = 7;
	localparam int SUM_W       = 28;
	localparam int VALUE_W     = 16;
	localparam int QPOS_W      = 6;
	localparam int RADIUS_W    = 6;
	localparam int STATUS_W    = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 7;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_RADIUS    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_LOADED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OUTSIDE    = 2'd2;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [RADIUS_W-1:0] RADIUS_RST    = 6'd1;
	localparam logic [COUNT_W-1:0]  ROW_COUNT_RST = 7'd64;
	localparam logic [COUNT_W-1:0]  COL_COUNT_RST = 7'd64;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic                req_type;
		logic [VALUE_W-1:0]  elem_value;
		logic [QPOS_W-1:0]   query_row;
		logic [QPOS_W-1:0]   query_col;
	} in_item_t;

	typedef struct packed {
		logic [SUM_W-1:0]    block_sum;
		logic [STATUS_W-1:0] status;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_QUERY,
		CMD_RESULT
	} cmd_op_t;

	// corner order: down/right, top/right, down/left, top/left
	typedef struct packed {
		cmd_op_t             op;
		logic [STATUS_W-1:0] status;
		logic [SUM_W-1:0]    data;
		coord_t              wr_row;
		coord_t              wr_col;
		logic [3:0]          rd_en;
		coord_t [3:0]        rd_row;
		coord_t [3:0]        rd_col;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD_WR,
		BK_QUERY,
		BK_QUERY_LAST,
		BK_EMIT
	} back_state_t;

endpackage

[design/sab_front.sv]
module sab_front #(
	parameter int MAX_ROWS = sab_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = sab_pkg::MAX_COLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  sab_pkg::in_item_t                in_data,
	input  logic                             cfg_wr_en,
	input  logic [sab_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sab_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             push,
	output sab_pkg::cmd_t                    push_cmd,
	input  logic                             queue_full
);
	import sab_pkg::*;

	localparam int ROWS_CAP = (MAX_ROWS < 127) ? MAX_ROWS : 127;
	localparam int COLS_CAP = (MAX_COLS < 127) ? MAX_COLS : 127;
	localparam logic [COUNT_W-1:0] ROWS_CAP_C = COUNT_W'(ROWS_CAP);
	localparam logic [COUNT_W-1:0] COLS_CAP_C = COUNT_W'(COLS_CAP);
	localparam logic [COUNT_W-1:0] ONE_C      = COUNT_W'(1);

	logic [RADIUS_W-1:0] radius_q;
	logic [COUNT_W-1:0]  row_count_q;
	logic [COUNT_W-1:0]  col_count_q;
	logic [COUNT_W-1:0]  load_row_q;
	coord_t              load_col_q;
	logic [SUM_W-1:0]    run_sum_q;

	logic [COUNT_W-1:0] rows;
	logic [COUNT_W-1:0] cols;
	logic               accept;
	logic               is_load;
	logic               load_ok;
	logic               complete;
	logic [SUM_W-1:0]   new_sum;
	coord_t             qr;
	coord_t             qc;
	coord_t             k;
	coord_t             top;
	coord_t             left;
	coord_t             down;
	coord_t             right;
	coord_t             next_col;
	coord_t [3:0]       crow;
	coord_t [3:0]       ccol;

	assign rows = (row_count_q == '0) ? ONE_C :
		((row_count_q > ROWS_CAP_C) ? ROWS_CAP_C : row_count_q);
	assign cols = (col_count_q == '0) ? ONE_C :
		((col_count_q > COLS_CAP_C) ? COLS_CAP_C : col_count_q);

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign is_load  = (in_data.req_type == REQ_LOAD);
	assign load_ok  = (load_row_q < rows) && (load_col_q < cols);
	assign complete = (load_row_q >= rows);
	assign new_sum  = run_sum_q + SUM_W'(in_data.elem_value);
	assign next_col = load_col_q + ONE_C;

	assign qr = {1'b0, in_data.query_row};
	assign qc = {1'b0, in_data.query_col};
	assign k  = {1'b0, radius_q};

	// clipped block, bottom and right exclusive
	assign top   = (qr > k) ? (qr - k) : '0;
	assign left  = (qc > k) ? (qc - k) : '0;
	assign down  = ((qr + k) >= rows) ? rows : (qr + k + ONE_C);
	assign right = ((qc + k) >= cols) ? cols : (qc + k + ONE_C);

	assign crow = {top, down, top, down};
	assign ccol = {left, left, right, right};

	assign push = accept && (!is_load || load_ok);

	always_comb begin
		push_cmd = '0;
		if (is_load) begin
			push_cmd.op        = CMD_LOAD;
			push_cmd.data      = new_sum;
			push_cmd.wr_row    = load_row_q;
			push_cmd.wr_col    = load_col_q;
			push_cmd.rd_en[0]  = (load_row_q != '0);
			push_cmd.rd_row[0] = load_row_q - ONE_C;
			push_cmd.rd_col[0] = load_col_q;
		end else if (!complete) begin
			push_cmd.op     = CMD_RESULT;
			push_cmd.status = STATUS_NOT_LOADED;
		end else if ((qr >= rows) || (qc >= cols)) begin
			push_cmd.op     = CMD_RESULT;
			push_cmd.status = STATUS_OUTSIDE;
		end else begin
			push_cmd.op     = CMD_QUERY;
			push_cmd.status = STATUS_OK;
			for (int i = 0; i < 4; i++) begin
				push_cmd.rd_en[i]  = (crow[i] != '0) && (ccol[i] != '0);
				push_cmd.rd_row[i] = crow[i] - ONE_C;
				push_cmd.rd_col[i] = ccol[i] - ONE_C;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= RADIUS_RST;
			row_count_q <= ROW_COUNT_RST;
			col_count_q <= COL_COUNT_RST;
			load_row_q  <= '0;
			load_col_q  <= '0;
			run_sum_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RADIUS: begin
					radius_q <= cfg_data[RADIUS_W-1:0];
				end
				REG_ROW_COUNT: begin
					row_count_q <= cfg_data;
					load_row_q  <= '0;
					load_col_q  <= '0;
					run_sum_q   <= '0;
				end
				REG_COL_COUNT: begin
					col_count_q <= cfg_data;
					load_row_q  <= '0;
					load_col_q  <= '0;
					run_sum_q   <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept && is_load && load_ok) begin
			if (next_col >= cols) begin
				load_col_q <= '0;
				load_row_q <= load_row_q + ONE_C;
				run_sum_q  <= '0;
			end else begin
				load_col_q <= next_col;
				run_sum_q  <= new_sum;
			end
		end
	end

endmodule

[design/sab_fifo.sv]
module sab_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sab_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output sab_pkg::cmd_t head_cmd
);
	import sab_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	cmd_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/sab_back.sv]
module sab_back #(
	parameter int MAX_ROWS = sab_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = sab_pkg::MAX_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  sab_pkg::cmd_t      head_cmd,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output sab_pkg::out_item_t out_data
);
	import sab_pkg::*;

	localparam int ROWS_CAP = (MAX_ROWS < 127) ? MAX_ROWS : 127;
	localparam int COLS_CAP = (MAX_COLS < 127) ? MAX_COLS : 127;
	localparam int ROW_AW   = (ROWS_CAP > 1) ? $clog2(ROWS_CAP) : 1;
	localparam int COL_AW   = (COLS_CAP > 1) ? $clog2(COLS_CAP) : 1;
	localparam int ADDR_W   = ROW_AW + COL_AW;
	localparam int DEPTH    = 1 << ADDR_W;

	logic [SUM_W-1:0]  mem [DEPTH];
	logic [SUM_W-1:0]  rdata_q;

	back_state_t       state_q;
	back_state_t       state_d;
	cmd_t              cur_q;
	logic [1:0]        idx_q;
	logic [1:0]        idx_d;
	logic [1:0]        data_idx;
	logic [SUM_W-1:0]  acc_q;
	logic [SUM_W-1:0]  acc_d;
	logic [SUM_W-1:0]  term;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              load_cur;
	logic              emit;
	logic              mem_re;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_raddr;
	logic [ADDR_W-1:0] mem_waddr;
	logic [SUM_W-1:0]  mem_wdata;

	function automatic logic [ADDR_W-1:0] addr_of(input coord_t r, input coord_t c);
		addr_of = {r[ROW_AW-1:0], c[COL_AW-1:0]};
	endfunction

	// corner whose read data is in rdata_q now
	assign data_idx  = idx_q - 2'd1;
	assign term      = cur_q.rd_en[data_idx] ? rdata_q : '0;
	assign mem_waddr = addr_of(cur_q.wr_row, cur_q.wr_col);
	assign mem_wdata = (cur_q.rd_en[0] ? rdata_q : '0) + cur_q.data;

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		acc_d     = acc_q;
		pop       = 1'b0;
		load_cur  = 1'b0;
		emit      = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = addr_of(cur_q.rd_row[idx_q], cur_q.rd_col[idx_q]);
		case (state_q)
			BK_IDLE: begin
				if (head_valid) begin
					pop       = 1'b1;
					load_cur  = 1'b1;
					mem_re    = 1'b1;
					mem_raddr = addr_of(head_cmd.rd_row[0], head_cmd.rd_col[0]);
					acc_d     = '0;
					idx_d     = 2'd1;
					case (head_cmd.op)
						CMD_LOAD:  state_d = BK_LOAD_WR;
						CMD_QUERY: state_d = BK_QUERY;
						default:   state_d = BK_EMIT;
					endcase
				end
			end
			BK_LOAD_WR: begin
				mem_we  = 1'b1;
				state_d = BK_IDLE;
			end
			BK_QUERY: begin
				mem_re = 1'b1;
				acc_d  = (data_idx == 2'd0 || data_idx == 2'd3) ? acc_q + term : acc_q - term;
				idx_d  = idx_q + 2'd1;
				if (idx_q == 2'd3) begin
					state_d = BK_QUERY_LAST;
				end
			end
			BK_QUERY_LAST: begin
				acc_d   = (data_idx == 2'd0 || data_idx == 2'd3) ? acc_q + term : acc_q - term;
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (!out_valid_q || out_ready) begin
					emit    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_cur) begin
			cur_q <= head_cmd;
		end
		if (emit) begin
			out_q.block_sum <= acc_q;
			out_q.status    <= cur_q.status;
		end
		acc_q <= acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[design/summed_area_box_sum.sv]
// summed-area box sum
// input channel (in_valid/in_ready/in_data): a load item appends the next matrix
// element in row-major order; a query item asks for the sum over the square of
// half-width radius around (query_row, query_col), clipped at the matrix edges.
// output channel (out_valid/out_ready/out_data): one item per query with
// block_sum and status (ok, table not fully loaded, cell outside the matrix).
// loads beyond row_count x col_count are dropped; writing row_count or col_count
// starts a fresh load, radius writes do not. write registers only while idle.
// a front stage tracks the load position and running row sum and turns each
// item into a command for a two-entry queue; the back end owns the one-port
// table memory. a load reads the row above, then writes the cell; a query does
// four corner reads on the single read port, then the result; a rejected
// query goes straight to the result.
// the input keeps accepting while the queue has room, also while a result waits.
// if the receiver stalls, the result holds in the output register and the back
// end waits after finishing its next query; loads still run meanwhile.
// reset clears control state and the load position; registers return to radius
// 1 and a 64 x 64 matrix; the table needs no clearing, it is reloaded by use.
`include "summed_area_box_sum_macros.svh"

module summed_area_box_sum #(
	parameter int MAX_ROWS = sab_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = sab_pkg::MAX_COLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  sab_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output sab_pkg::out_item_t               out_data,
	input  logic                             cfg_wr_en,
	input  logic [sab_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sab_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sab_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic fifo_full;
	logic fifo_pop;
	logic fifo_valid;
	cmd_t fifo_head;
	logic result_err;
	logic status_known;

	sab_front #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_cmd  (push_cmd),
		.queue_full(fifo_full)
	);

	sab_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.head_valid(fifo_valid),
		.head_cmd  (fifo_head)
	);

	sab_back #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(fifo_valid),
		.head_cmd  (fifo_head),
		.pop       (fifo_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign result_err   = out_valid && (out_data.status != STATUS_OK);
	assign status_known = (out_data.status == STATUS_OK) ||
		(out_data.status == STATUS_NOT_LOADED) || (out_data.status == STATUS_OUTSIDE);

	`SAB_ASSERT(a_pop_has_head, clk, arst_n, fifo_pop, fifo_valid)
	`SAB_ASSERT(a_err_zero_sum, clk, arst_n, result_err, out_data.block_sum == '0)
	`SAB_ASSERT(a_status_known, clk, arst_n, out_valid, status_known)
	`SAB_ASSERT_NEXT(a_no_result_after_pop, clk, arst_n, fifo_pop, !$rose(out_valid))

endmodule
